// ===== rtl/rmsn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_pkg: shared types and constants for the RMS row normaliser
// Widths of the fixed-point formats and the controller/datapath link.
// ----------------------------------------------------------------------------
package rmsn_pkg;

  localparam int DW       = 16;   // sample, gain and result width
  localparam int LEN_W    = 7;    // row length register and element count
  localparam int EPS_W    = 16;
  localparam int SUM_W    = 38;   // sum of squares
  localparam int MS_W     = 39;   // mean square plus epsilon, Q15.24
  localparam int INV_W    = 29;   // inverse root, 16 fractional bits
  localparam int INV_TOP  = 28;
  localparam int BIT_W    = 5;    // index of the inverse root bit under test
  localparam int SQ_W     = 2 * INV_W;
  localparam int DIV_N    = 57;   // dividend width of the shared divider
  localparam int DIV_D    = MS_W; // divisor width
  localparam int DIV_CNT_W = 6;
  localparam int SG_W     = 2 * DW;
  localparam int PROD_W   = SG_W + INV_W + 1;
  localparam int OUT_SHIFT = 28;

  localparam int ADDR_W   = 3;
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_EPSILON    = 1'b1;

  typedef struct packed {
    logic load;
    logic div_ms;
    logic ms_latch;
    logic div_lim;
    logic root_init;
    logic root_sq;
    logic root_cmp;
    logic inv_sat;
    logic emit_init;
    logic emit_rd;
    logic emit_mul1;
    logic emit_mul2;
    logic emit_rnd;
    logic emit_next;
    logic row_clear;
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic div_done;
    logic ms_zero;
    logic root_last;
    logic emit_last;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/rmsn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_div: restoring integer divider
// Produces one quotient bit per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module rmsn_div
  import rmsn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic [DIV_N-1:0] quotient,
  output logic             done
);

  logic [DIV_D:0]       rem;
  logic [DIV_D-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_D+1:0]     shifted;
  logic [DIV_D+1:0]     diff;

  assign shifted = {rem, quotient[DIV_N-1]};
  assign diff    = shifted - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // The dividend shifts out of the top as quotient bits enter below.
        if (!diff[DIV_D+1]) begin
          rem      <= diff[DIV_D:0];
          quotient <= {quotient[DIV_N-2:0], 1'b1};
        end else begin
          rem      <= shifted[DIV_D:0];
          quotient <= {quotient[DIV_N-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsn_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_datapath: row buffer, sum of squares, inverse root and output scaling
// Acts on commands from the controller and reports status back.
// ----------------------------------------------------------------------------
module rmsn_datapath
  import rmsn_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic        [LEN_W-1:0] row_length,
  input  logic        [EPS_W-1:0] epsilon,
  input  logic signed [DW-1:0]    sample,
  input  logic signed [DW-1:0]    gain,
  output logic signed [DW-1:0]    normalised
);

  localparam int MEM_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [DW-1:0] sample_mem [MAX_DIM];
  logic signed [DW-1:0] gain_mem   [MAX_DIM];

  logic [SUM_W-1:0]   square_sum;
  logic [LEN_W-1:0]   element_count;
  logic [LEN_W-1:0]   count_next;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   widx;
  logic [LEN_W-1:0]   k;
  logic [MS_W-1:0]    ms;
  logic [DIV_N-1:0]   limit;
  logic [INV_W-1:0]   inv;
  logic [INV_W-1:0]   trial;
  logic [BIT_W-1:0]   bit_idx;
  logic [SQ_W-1:0]    trial_sq;
  logic signed [DW-1:0]     rd_sample;
  logic signed [DW-1:0]     rd_gain;
  logic signed [SG_W-1:0]   sg;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-OUT_SHIFT-1:0] scaled;
  logic signed [SG_W-1:0]   sq;

  logic             div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;
  logic [DIV_N-1:0] div_quotient;

  always_comb begin
    if (row_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (row_length > LEN_W'(MAX_DIM)) begin
      len_eff = LEN_W'(MAX_DIM);
    end else begin
      len_eff = row_length;
    end
  end

  assign widx       = (element_count >= LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM - 1)
                                                         : element_count;
  assign count_next = widx + 1'b1;
  assign sq         = sample * sample;

  // Both divisions share one unit: the mean square, then 2^56 / ms.
  assign div_start    = cmd.div_ms | cmd.div_lim;
  assign div_dividend = cmd.div_ms ? DIV_N'(square_sum) : DIV_N'(1) << (DIV_N - 1);
  assign div_divisor  = cmd.div_ms ? DIV_D'(element_count) : ms;

  rmsn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (status.div_done)
  );

  assign trial = inv | (INV_W'(1) << bit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      element_count <= '0;
    end else if (cmd.load) begin
      square_sum    <= square_sum + SUM_W'(unsigned'(sq));
      element_count <= count_next;
    end else if (cmd.row_clear) begin
      square_sum    <= '0;
      element_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_mem[widx[MEM_AW-1:0]] <= sample;
      gain_mem[widx[MEM_AW-1:0]]   <= gain;
    end
    if (cmd.emit_rd) begin
      rd_sample <= sample_mem[k[MEM_AW-1:0]];
      rd_gain   <= gain_mem[k[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ms_latch) begin
      ms <= div_quotient[MS_W-1:0] + MS_W'(epsilon);
    end
    if (status.div_done && !cmd.ms_latch) begin
      limit <= div_quotient;
    end
    if (cmd.root_init) begin
      inv     <= '0;
      bit_idx <= BIT_W'(INV_TOP);
    end else if (cmd.inv_sat) begin
      inv <= '1;
    end else if (cmd.root_cmp) begin
      if ({1'b0, limit} >= trial_sq) begin
        inv <= trial;
      end
      bit_idx <= bit_idx - 1'b1;
    end
    if (cmd.root_sq) begin
      trial_sq <= trial * trial;
    end
    if (cmd.emit_init) begin
      k <= '0;
    end else if (cmd.emit_next) begin
      k <= k + 1'b1;
    end
    if (cmd.emit_mul1) begin
      sg <= rd_sample * rd_gain;
    end
    if (cmd.emit_mul2) begin
      prod <= PROD_W'(sg) * $signed({1'b0, inv});
    end
    if (cmd.emit_rnd) begin
      if (scaled > $signed((PROD_W-OUT_SHIFT)'(2**(DW-1) - 1))) begin
        normalised <= DW'(2**(DW-1) - 1);
      end else if (scaled < -$signed((PROD_W-OUT_SHIFT)'(2**(DW-1)))) begin
        normalised <= {1'b1, {(DW-1){1'b0}}};
      end else begin
        normalised <= scaled[DW-1:0];
      end
    end
  end

  // Half-up rounding: add half an LSB, then an arithmetic shift floors.
  assign rounded = prod + (PROD_W'(1) << (OUT_SHIFT - 1));
  assign scaled  = rounded[PROD_W-1:OUT_SHIFT];

  assign status.row_done  = count_next >= len_eff;
  assign status.ms_zero   = (ms == '0);
  assign status.root_last = (bit_idx == '0);
  assign status.emit_last = (k == element_count - 1'b1);

endmodule
`default_nettype wire

// ===== rtl/rmsn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_ctrl: sequencing state machine
// Steps a row through loading, division, inverse root and emission.
// ----------------------------------------------------------------------------
module rmsn_ctrl
  import rmsn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIV_MS, ST_MS_WAIT, ST_MS_CHECK, ST_LIM_WAIT, ST_ROOT_SQ,
    ST_ROOT_CMP, ST_RD, ST_MUL1, ST_MUL2, ST_RND, ST_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.row_done) begin
            state_next = ST_DIV_MS;
          end
        end
      end
      ST_DIV_MS: begin
        cmd.div_ms = 1'b1;
        state_next = ST_MS_WAIT;
      end
      ST_MS_WAIT: begin
        if (status.div_done) begin
          cmd.ms_latch = 1'b1;
          state_next   = ST_MS_CHECK;
        end
      end
      ST_MS_CHECK: begin
        if (status.ms_zero) begin
          cmd.inv_sat   = 1'b1;
          cmd.emit_init = 1'b1;
          state_next    = ST_RD;
        end else begin
          cmd.div_lim = 1'b1;
          state_next  = ST_LIM_WAIT;
        end
      end
      ST_LIM_WAIT: begin
        if (status.div_done) begin
          cmd.root_init = 1'b1;
          state_next    = ST_ROOT_SQ;
        end
      end
      ST_ROOT_SQ: begin
        cmd.root_sq = 1'b1;
        state_next  = ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        cmd.root_cmp = 1'b1;
        if (status.root_last) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_RD;
        end else begin
          state_next = ST_ROOT_SQ;
        end
      end
      ST_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.emit_mul1 = 1'b1;
        state_next    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.emit_mul2 = 1'b1;
        state_next    = ST_RND;
      end
      ST_RND: begin
        cmd.emit_rnd = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (status.emit_last) begin
            cmd.row_clear = 1'b1;
            state_next    = ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rms_norm_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_norm_row: RMS normalisation of one row of Q3.12 samples
// Buffers a row, finds its inverse RMS and streams out the scaled samples.
// ----------------------------------------------------------------------------
// Each input transfer carries one sample and its gain, and transfers may
// arrive back to back; the row buffer and the sum of squares fill as
// transfers arrive. The transfer that completes the configured row length
// starts the row computation, during which no input is taken: the mean
// square comes from a shared restoring divider, a zero check follows, then
// the divide of 2^56 by the mean square, and the root itself is found one
// bit at a time over 29 bits, each bit a squaring step and a compare step.
// Each result then goes through a buffer read, two multiplies, rounding and
// the output transfer, which waits while the sink holds tready low. The last
// result of a row carries tlast. A zero mean square plus epsilon gives the
// largest inverse root, and results saturate to the Q3.12 range. Register
// writes belong between rows.
// ----------------------------------------------------------------------------
module rms_norm_row
  import rmsn_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [2*DW-1:0]   s_tdata,   // [15:0] sample, [31:16] gain
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DW-1:0]     m_tdata,   // [15:0] normalised
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LEN_W-1:0] row_length;
  logic [EPS_W-1:0] epsilon;
  cmd_t             cmd;
  status_t          status;
  logic signed [DW-1:0] normalised;

  // Register i lies at byte address 4*i; address bit 2 picks the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_W'(64);
      epsilon    <= EPS_W'(17);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ROW_LENGTH: row_length <= pwdata[LEN_W-1:0];
        REG_EPSILON:    epsilon    <= pwdata[EPS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_LENGTH: prdata = 32'(row_length);
      REG_EPSILON:    prdata = 32'(epsilon);
      default:        prdata = '0;
    endcase
  end

  rmsn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rmsn_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .row_length (row_length),
    .epsilon    (epsilon),
    .sample     (s_tdata[DW-1:0]),
    .gain       (s_tdata[2*DW-1:DW]),
    .normalised (normalised)
  );

  assign m_tdata = normalised;
  assign m_tlast = m_tvalid & status.emit_last;

endmodule
`default_nettype wire

// ===== rtl/rmsn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_props: port-level checks for the RMS row normaliser
// Watches both stream sides and is bound to the top level.
// ----------------------------------------------------------------------------
module rmsn_props
  import rmsn_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [DW-1:0] m_tdata,
  input logic          m_tlast
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Rows are handled one at a time: no input is taken while results go out.
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during emission");

  // The final result of a row returns the block to loading.
  a_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not ready after last result");

  // After reset the block waits for input.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> s_tready && !m_tvalid)
    else $error("wrong state after reset");

endmodule

bind rms_norm_row rmsn_props u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/rmsn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsn_checker: result predictor and comparator for the RMS row normaliser
// Watches the input, output and register channels, computes each row's
// scaled results and compares every output transfer against them in order.
// ----------------------------------------------------------------------------
module rmsn_checker
  import rmsn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [2*DW-1:0]   s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DW-1:0]     m_tdata,
  input  logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending,
  output int                rows_seen
);

  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
  } norm_out_t;

  norm_out_t         norm_queue[$];
  logic [LEN_W-1:0]  cfg_len;
  logic [EPS_W-1:0]  cfg_eps;
  logic signed [DW-1:0] row_samples[64];
  logic signed [DW-1:0] row_gains[64];
  logic [SUM_W-1:0]  sq_acc;
  int                row_fill;

  assign pending = norm_queue.size();

  function automatic logic [INV_W-1:0] inv_root(input logic [63:0] ms);
    logic [63:0] lim, r, t;
    if (ms == 0) return {INV_W{1'b1}};
    lim = (64'd1 << 56) / ms;
    r = 0;
    for (int b = INV_TOP; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= lim) r = t;
    end
    return r[INV_W-1:0];
  endfunction

  function automatic logic [DW-1:0] scale_elem(input logic signed [DW-1:0] s,
                                               input logic [INV_W-1:0] inv,
                                               input logic signed [DW-1:0] g);
    logic signed [63:0] v, q;
    v = 64'(s) * $signed({35'd0, inv}) * 64'(g) + (64'sd1 <<< (OUT_SHIFT - 1));
    q = v >>> OUT_SHIFT; // arithmetic shift floors, matching round half up
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[DW-1:0];
  endfunction

  task automatic absorb_elem(input logic [2*DW-1:0] d);
    int len, idx;
    logic [63:0] ms;
    logic [INV_W-1:0] inv;
    len = (cfg_len == 0) ? 1 : (cfg_len > 64) ? 64 : cfg_len;
    idx = (row_fill >= 64) ? 63 : row_fill;
    row_samples[idx] = d[DW-1:0];
    row_gains[idx]   = d[2*DW-1:DW];
    sq_acc = sq_acc + SUM_W'(64'($signed(d[DW-1:0])) * 64'($signed(d[DW-1:0])));
    row_fill = idx + 1;
    if (row_fill >= len) begin
      ms = 64'(sq_acc) / row_fill + cfg_eps;
      inv = inv_root(ms);
      for (int k = 0; k < row_fill; k++)
        norm_queue.push_back('{scale_elem(row_samples[k], inv, row_gains[k]),
                               k == row_fill - 1});
      sq_acc = 0;
      row_fill = 0;
      rows_seen++;
    end
  endtask

  always @(posedge clk) begin
    norm_out_t want;
    if (rst) begin
      cfg_len = 64; cfg_eps = 17; sq_acc = 0; row_fill = 0;
      fail_count = 0; rows_seen = 0;
      norm_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_W'(4 * REG_ROW_LENGTH)) cfg_len = pwdata[LEN_W-1:0];
        else if (paddr == ADDR_W'(4 * REG_EPSILON)) cfg_eps = pwdata[EPS_W-1:0];
      end
      if (s_tvalid && s_tready) absorb_elem(s_tdata);
      if (m_tvalid && m_tready) begin
        if (norm_queue.size() == 0) begin
          $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = norm_queue.pop_front();
          if (want.value !== m_tdata || want.last !== m_tlast) begin
            $display("%0t: mismatch expected %h last %b, actual %h last %b",
                     $time, want.value, want.last, m_tdata, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the RMS row normaliser
// Drives rows of samples and gains under several register settings, with
// bursty input, a stalling sink and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rmsn_pkg::*;

  logic              clk, rst;
  logic              s_tvalid, s_tready;
  logic [2*DW-1:0]   s_tdata;
  logic              m_tvalid, m_tready;
  logic [DW-1:0]     m_tdata;
  logic              m_tlast;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  int                fail_count, pending, rows_seen;
  bit                hold_sink;

  rms_norm_row uut (.*);

  rmsn_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Generous ceiling: the run fails if it has not finished by then.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The sink stalls on its own pattern, and holds off fully while asked to.
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_sink) m_tready <= 0;
      else if ($urandom_range(0, 3) == 0) m_tready <= ($urandom_range(0, 1) == 0);
      else m_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] v);
    s_tvalid <= 0;
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offer one transfer and hold it until accepted; a random gap may follow.
  task automatic send_elem(input logic [DW-1:0] s, input logic [DW-1:0] g);
    s_tvalid <= 1;
    s_tdata  <= {g, s};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if ($urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Wait for every expected result, then let the block settle before a write.
  task automatic drain;
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_config(input int len, input int eps);
    drain();
    reg_write(ADDR_W'(4 * REG_ROW_LENGTH), len);
    reg_write(ADDR_W'(4 * REG_EPSILON), eps);
  endtask

  function automatic logic [DW-1:0] rand_word(input int kind);
    case (kind)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return DW'($urandom_range(0, 255) - 128);
      default: return DW'($urandom);
    endcase
  endfunction

  initial begin
    int len;
    rst = 1; s_tvalid = 0; s_tdata = 0; hold_sink = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: single-element rows at the extremes, zero mean square with
    // zero epsilon, then large epsilon.
    set_config(1, 0);
    send_elem(16'h0000, 16'h7fff);
    send_elem(16'h7fff, 16'h7fff);
    send_elem(16'h8000, 16'h8000);
    send_elem(16'h8000, 16'h7fff);
    send_elem(16'h0001, 16'h1000);
    set_config(3, 65535);
    for (int i = 0; i < 6; i++) send_elem(rand_word(i % 5), rand_word((i + 2) % 5));
    // Row length zero behaves as one; above the maximum saturates.
    set_config(0, 17);
    send_elem(16'h1234, 16'hedcb);
    send_elem(16'hffff, 16'h0000);
    // Tiny samples with large gains drive the output into saturation.
    set_config(4, 0);
    for (int i = 0; i < 4; i++) send_elem(16'h0001 << i, 16'h8000 ^ i);
    // Lowering the row length mid-row closes the row on the next element.
    set_config(8, 5);
    for (int i = 0; i < 3; i++) send_elem(DW'($urandom), DW'($urandom));
    reg_write(ADDR_W'(4 * REG_ROW_LENGTH), 2);
    send_elem(DW'($urandom), DW'($urandom));

    // A full row of 64 after a length above the maximum.
    set_config(127, $urandom_range(0, 65535));
    for (int i = 0; i < 64; i++)
      send_elem(rand_word($urandom_range(3, 4)), rand_word($urandom_range(0, 4)));
    // Rows of six while the sink holds off: the first row's results back up
    // and the next row's transfers wait at the input.
    set_config(6, $urandom_range(0, 65535));
    fork
      begin
        hold_sink = 1;
        repeat (600) @(negedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 18; i++)
        send_elem(rand_word($urandom_range(0, 6)), rand_word($urandom_range(0, 6)));
    join
    for (int r = 0; r < 2; r++) begin
      len = $urandom_range(1, 12);
      set_config(len, (r % 3 == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535));
      for (int i = 0; i < len; i++)
        send_elem(rand_word($urandom_range(0, 6)), rand_word($urandom_range(0, 6)));
    end
    s_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d rows: lengths 0 to 127 written, epsilon 0 to 65535,", rows_seen);
    $display("saturating rows, a mid-row length change and a long sink hold-off.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== rms_norm_row.f =====
rtl/rmsn_pkg.sv
rtl/rmsn_div.sv
rtl/rmsn_datapath.sv
rtl/rmsn_ctrl.sv
rtl/rms_norm_row.sv
rtl/rmsn_checker.sv
sim/rmsn_checker.sv
sim/tb_top.sv
